### design/g4rle_pkg.sv
// g4rle_pkg: types, constants and helpers shared by the 4-bit grayscale
// run-length encoder. No dependencies; compile first.

package g4rle_pkg;

   // Run length limits for the two run classes
   localparam logic [11:0] LONG_LIMIT  = 12'hFFF;
   localparam logic [11:0] SHORT_LIMIT = 12'h00F;

   // Color codes that use the two-byte long run format
   localparam logic [3:0] COLOR_BLACK = 4'h0;
   localparam logic [3:0] COLOR_WHITE = 4'hF;

   // Default depth of the run event queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // One closed run
   typedef struct packed {
      logic [3:0]  color;
      logic [11:0] len;
   } run_type;

   // What one pixel word closes: up to two runs, plus the image end flag
   typedef struct packed {
      logic    has_a;   // run closed by a color change
      run_type run_a;
      logic    has_b;   // run closed by its limit or by image end
      run_type run_b;
      logic    last;    // pixel was the last of the image
   } event_type;

   // Black and white runs are coded in two bytes
   function automatic logic is_long_color(input logic [3:0] color);
      return (color == COLOR_BLACK) || (color == COLOR_WHITE);
   endfunction

   // Number of code bytes one run occupies (0 when absent)
   function automatic logic [1:0] run_bytes(input logic present, input run_type run);
      logic [1:0] n;
      if (!present) begin
         n = 2'd0;
      end else if (is_long_color(run.color)) begin
         n = 2'd2;
      end else begin
         n = 2'd1;
      end
      return n;
   endfunction

   // Byte 'part' of a run: long runs give color|len[11:8] then len[7:0]
   function automatic logic [7:0] run_byte(input run_type run, input logic part);
      logic [7:0] b;
      if (is_long_color(run.color)) begin
         b = part ? run.len[7:0] : {run.color, run.len[11:8]};
      end else begin
         b = {run.color, run.len[3:0]};
      end
      return b;
   endfunction

endpackage

### design/g4rle_if.sv
// g4rle_if: valid/ready channel interfaces for the pixel input and the
// code byte output of the run-length encoder. No dependencies.

interface g4rle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_value;
   logic       image_end;

   modport source (output valid, output pixel_value, output image_end, input ready);
   modport sink   (input valid, input pixel_value, input image_end, output ready);
endinterface

interface g4rle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       item_done;
   logic       stream_end;

   modport source (output valid, output code_byte, output item_done,
                   output stream_end, input ready);
   modport sink   (input valid, input code_byte, input item_done,
                   input stream_end, output ready);
endinterface

### design/gray4_run_length_encoder_core.sv
// gray4_run_length_encoder_core: top level of the 4-bit grayscale run-length
// encoder. Depends on g4rle_pkg, g4rle_if, g4rle_front, g4rle_fifo, g4rle_back.
//
// Usage:
//   req_chan carries one pixel word per handshake: pixel_value (only bits 7..4
//   are coded) and image_end, which marks the last pixel of the image.
//   rsp_chan carries one code byte per word, with item_done on the last byte
//   a pixel caused and stream_end on the final byte of the image.
//   A pixel that closes no run produces no output word.
// Timing:
//   The front takes a pixel every cycle while the event queue has room.
//   A pixel that closes runs yields 1 to 4 bytes; the back sends them one
//   per cycle unless stalled, via the event queue and the output register.
//   Throughput is one pixel per cycle as long as the average byte count per
//   pixel stays at or below one; the QUEUE_DEPTH event queue absorbs bursts.
// Reset (synchronous, active high) drops any open run and empties the queue.
// When the receiver stalls, the output word holds; the queue fills, and then
// req_chan.ready drops until the back drains an event.

module gray4_run_length_encoder_core #(
   parameter int QUEUE_DEPTH = g4rle_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   g4rle_req_if.sink   req_chan,
   g4rle_rsp_if.source rsp_chan
);

   logic                 push;
   g4rle_pkg::event_type push_event;
   logic                 queue_full;
   logic                 pop;
   g4rle_pkg::event_type head_event;
   logic                 head_valid;

   g4rle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_event (push_event)
   );

   g4rle_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .full       (queue_full),
      .pop        (pop),
      .head_event (head_event),
      .head_valid (head_valid)
   );

   g4rle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_event (head_event),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

### design/g4rle_front.sv
// g4rle_front: accepts pixel words, tracks the open run and classifies
// each pixel into a run event. Depends on g4rle_pkg and g4rle_req_if.

module g4rle_front (
   input  logic                 clock,
   input  logic                 reset,
   g4rle_req_if.sink            req_chan,
   input  logic                 queue_full,
   output logic                 push,
   output g4rle_pkg::event_type push_event
);

   logic [3:0]  color_ff, color_in;
   logic [11:0] count_ff, count_in;
   logic        open_ff, open_in;

   logic [3:0]  pix_color;
   logic        change;
   logic        cont;
   logic [3:0]  cur_color;
   logic [11:0] cur_count;
   logic [11:0] limit;
   logic        close;
   logic        accept;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;

   // Classify the pixel against the open run
   always_comb begin
      pix_color = req_chan.pixel_value[7:4];
      change    = open_ff && (pix_color != color_ff);
      cont      = open_ff && !change;
      cur_color = cont ? color_ff : pix_color;
      cur_count = cont ? (count_ff + 12'd1) : 12'd1;
      limit     = g4rle_pkg::is_long_color(cur_color) ? g4rle_pkg::LONG_LIMIT
                                                      : g4rle_pkg::SHORT_LIMIT;
      close     = (cur_count >= limit) || req_chan.image_end;
   end

   // Event word for the queue
   always_comb begin
      push_event.has_a       = change;
      push_event.run_a.color = color_ff;
      push_event.run_a.len   = count_ff;
      push_event.has_b       = close;
      push_event.run_b.color = cur_color;
      push_event.run_b.len   = cur_count;
      push_event.last        = req_chan.image_end;
      push                   = accept && (change || close);
   end

   // Run state update
   always_comb begin
      color_in = color_ff;
      count_in = count_ff;
      open_in  = open_ff;
      if (accept) begin
         if (close) begin
            color_in = 4'h0;
            count_in = 12'd0;
            open_in  = 1'b0;
         end else begin
            color_in = cur_color;
            count_in = cur_count;
            open_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= 4'h0;
         count_ff <= 12'd0;
         open_ff  <= 1'b0;
      end else begin
         color_ff <= color_in;
         count_ff <= count_in;
         open_ff  <= open_in;
      end
   end

endmodule

### design/g4rle_fifo.sv
// g4rle_fifo: small queue of run events between the front and the back.
// Depends on g4rle_pkg.

module g4rle_fifo #(
   parameter int DEPTH = g4rle_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  g4rle_pkg::event_type push_event,
   output logic                 full,
   input  logic                 pop,
   output g4rle_pkg::event_type head_event,
   output logic                 head_valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   g4rle_pkg::event_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_event = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule

### design/g4rle_back.sv
// g4rle_back: expands queued run events into code bytes via a registered output
// stage, one byte per cycle unless stalled. Depends on g4rle_pkg, g4rle_rsp_if.

module g4rle_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  g4rle_pkg::event_type head_event,
   output logic                 pop,
   g4rle_rsp_if.source          rsp_chan
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       done_ff, done_in;
   logic       end_ff, end_in;

   logic [1:0] na, nb;
   logic [2:0] total;
   logic [1:0] part_b;
   logic       last_byte;
   logic       load;
   logic [7:0] next_byte;

   // Pick the byte at idx_ff within the event's byte sequence
   always_comb begin
      na        = g4rle_pkg::run_bytes(head_event.has_a, head_event.run_a);
      nb        = g4rle_pkg::run_bytes(head_event.has_b, head_event.run_b);
      total     = {1'b0, na} + {1'b0, nb};
      part_b    = idx_ff - na;
      last_byte = ({1'b0, idx_ff} + 3'd1) == total;
      if (idx_ff < na) begin
         next_byte = g4rle_pkg::run_byte(head_event.run_a, idx_ff[0]);
      end else begin
         next_byte = g4rle_pkg::run_byte(head_event.run_b, part_b[0]);
      end
   end

   assign load = head_valid && (!valid_ff || rsp_chan.ready);
   assign pop  = load && last_byte;

   // Output register and byte index
   always_comb begin
      idx_in   = idx_ff;
      byte_in  = byte_ff;
      done_in  = done_ff;
      end_in   = end_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = last_byte ? 2'd0 : idx_ff + 2'd1;
         byte_in  = next_byte;
         done_in  = last_byte;
         end_in   = last_byte && head_event.last;
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      done_ff <= done_in;
      end_ff  <= end_in;
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.code_byte  = byte_ff;
   assign rsp_chan.item_done  = done_ff;
   assign rsp_chan.stream_end = end_ff;

endmodule
